### rtl/lste_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lste_pkg
// Shared types and constants for the star twinkle engine.
// ----------------------------------------------------------------------------
package lste_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE          = 3'd0;
    localparam logic [2:0] CFG_SPARKLE_THRSH = 3'd1;
    localparam logic [2:0] CFG_GALAXY_THRSH  = 3'd2;
    localparam logic [2:0] CFG_BRIGHT_CAP    = 3'd3;
    localparam logic [2:0] CFG_NORMAL_PEAK   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Pattern modes
    localparam logic MODE_SPARKLE = 1'b0;
    localparam logic MODE_GALAXY  = 1'b1;

    // Register reset values
    localparam logic [7:0]  RST_SPARKLE_THRSH = 8'd5;
    localparam logic [15:0] RST_GALAXY_THRSH  = 16'd12;
    localparam logic [7:0]  RST_BRIGHT_CAP    = 8'd10;
    localparam logic [7:0]  RST_NORMAL_PEAK   = 8'd200;

    // Level arithmetic
    localparam logic [7:0] LEVEL_MAX    = 8'd255;
    localparam logic [7:0] SPARKLE_RISE = 8'd4;
    localparam logic [7:0] SPARKLE_FALL = 8'd2;

    typedef struct packed {
        logic [7:0]  led_index;
        logic [15:0] random_value;
        logic        frame_start;
    } t_in;

    typedef struct packed {
        logic [7:0] out_index;
        logic [7:0] brightness;
    } t_out;

    // Per-LED state word held in memory
    typedef struct packed {
        logic [7:0] level;
        logic       rising;
        logic       bright_tier;
    } t_entry;

endpackage : lste_pkg
`default_nettype wire

### rtl/lste_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lste_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lste_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  wire                                    i_clk,
    input  wire                                    i_we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                        i_wdata,
    input  wire                                    i_re,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : lste_ram
`default_nettype wire

### rtl/led_star_twinkle_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_star_twinkle_engine_core
// Per-LED twinkle state machine: each input transaction updates one LED's
// brightness from a random value, in sparkle or two-tier galaxy mode.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                              | Direction | Handshake
//  ---------+--------------------------------------+-----------+-------------
//  in       | i_in_valid, o_in_ready, i_in         | input     | valid/ready
//  out      | o_out_valid, i_out_ready, o_out      | output    | valid/ready
//  cfg      | i_cfg_we, i_cfg_index, i_cfg_data    | input     | write strobe
//
//  Cycles: one transaction per cycle while the output drains; the result
//  passes the RAM read register, then the update into the output buffer.
//  The rate is set by the single read-modify-write on the state RAM; a
//  same-LED transaction right behind another is served by forwarding.
//  Reset: per-entry valid flops make every LED read as dark; no clear pass.
//  Input ready is held low while reset is asserted.
//  Stalls: a two-entry output buffer absorbs the in-flight transaction, so
//  input ready drops only when the buffer would overflow.
// ----------------------------------------------------------------------------
module led_star_twinkle_engine_core #(
    parameter int LED_COUNT = 256
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,

    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire lste_pkg::t_in             i_in,

    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output lste_pkg::t_out                 o_out,

    input  wire                            i_cfg_we,
    input  wire [lste_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [lste_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Only 8 index bits reach the block, so at most 256 entries are live.
    localparam int MEM_DEPTH = (LED_COUNT < 256) ? LED_COUNT : 256;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int EW        = $bits(lste_pkg::t_entry);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        r_mode;
    logic [7:0]  r_sparkle_thrsh;
    logic [15:0] r_galaxy_thrsh;
    logic [7:0]  r_bright_cap;
    logic [7:0]  r_normal_peak;

    // ------------------------------------------------------------------
    // Pipeline / state registers
    // ------------------------------------------------------------------
    logic                 r_s1_valid;       // transaction in update stage
    lste_pkg::t_in        r_s1;             // its payload
    logic                 r_s1_in_range;

    logic [MEM_DEPTH-1:0] r_valid;          // entry written since reset
    logic                 r_wb_valid;       // last cycle's write-back
    logic [AW-1:0]        r_wb_addr;
    lste_pkg::t_entry     r_wb_data;

    logic [7:0]           r_live_cnt;
    logic [7:0]           r_frame_cnt;

    // Output buffer (two entries)
    lste_pkg::t_out       r_buf [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_cnt;

    // ------------------------------------------------------------------
    // Next-state signals
    // ------------------------------------------------------------------
    logic                 in_accept;
    logic                 in_range;
    logic [AW-1:0]        s1_addr;
    lste_pkg::t_entry     ram_rdata;
    lste_pkg::t_entry     cur;
    lste_pkg::t_entry     n_entry;
    logic                 n_wb_valid;
    logic [7:0]           n_live_cnt;
    logic [7:0]           n_frame_cnt;
    logic [7:0]           n_brightness;
    logic                 pop;
    logic [2:0]           occ_next;

    // Update-stage temporaries
    logic                 born;
    logic [7:0]           lvl1;
    logic                 rise1;
    logic                 tier1;
    logic [8:0]           sum9;
    logic [7:0]           inc8;
    logic [7:0]           peak;
    logic                 was_bright;
    logic                 now_bright;

    assign pop         = o_out_valid & i_out_ready;
    // Occupancy once the in-flight transaction lands and the head may leave.
    assign occ_next    = 3'(r_cnt) + 3'(r_s1_valid) - 3'(pop);
    assign o_in_ready  = i_rst_n & (occ_next < 3'd2);
    assign in_accept   = i_in_valid & o_in_ready;
    assign in_range    = (32'(i_in.led_index) < LED_COUNT);

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_buf[r_rd_ptr];

    assign s1_addr     = r_s1.led_index[AW-1:0];

    lste_ram #(
        .WIDTH (EW),
        .DEPTH (MEM_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (n_wb_valid),
        .i_waddr (s1_addr),
        .i_wdata (n_entry),
        .i_re    (in_accept),
        .i_raddr (i_in.led_index[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Update stage: forward, compute new entry and counters
    // ------------------------------------------------------------------
    always_comb begin
        // Back-to-back hit on the same LED: RAM returned pre-write data.
        if (r_wb_valid && (r_wb_addr == s1_addr)) begin
            cur = r_wb_data;
        end else if (r_s1_in_range && r_valid[s1_addr]) begin
            cur = ram_rdata;
        end else begin
            cur = '0;
        end

        // Frame snapshot happens before the LED update.
        n_frame_cnt = r_s1.frame_start ? r_live_cnt : r_frame_cnt;

        born  = 1'b0;
        lvl1  = cur.level;
        rise1 = cur.rising;
        tier1 = cur.bright_tier;
        sum9  = '0;
        inc8  = '0;
        peak  = lste_pkg::LEVEL_MAX;
        n_entry = cur;

        if (r_mode == lste_pkg::MODE_SPARKLE) begin
            born = (cur.level == 8'd0) &&
                   (r_s1.random_value[7:0] < r_sparkle_thrsh);
            if (born) begin
                lvl1  = 8'd1;
                rise1 = 1'b1;
            end
            n_entry.rising      = rise1;
            n_entry.bright_tier = tier1;
            if (rise1) begin
                sum9 = {1'b0, lvl1} + {1'b0, lste_pkg::SPARKLE_RISE};
                if (sum9 >= {1'b0, lste_pkg::LEVEL_MAX}) begin
                    n_entry.level  = lste_pkg::LEVEL_MAX;
                    n_entry.rising = 1'b0;
                end else begin
                    n_entry.level  = sum9[7:0];
                end
            end else if (lvl1 > lste_pkg::SPARKLE_FALL) begin
                n_entry.level = lvl1 - lste_pkg::SPARKLE_FALL;
            end else begin
                n_entry.level = 8'd0;
            end
        end else begin
            born = (cur.level == 8'd0) &&
                   (r_s1.random_value < r_galaxy_thrsh);
            if (born) begin
                lvl1  = 8'd1;
                rise1 = 1'b1;
                // Cap is at most 255, so the count never saturates here.
                if (n_frame_cnt < r_bright_cap) begin
                    tier1       = 1'b1;
                    n_frame_cnt = n_frame_cnt + 8'd1;
                end else begin
                    tier1 = 1'b0;
                end
            end
            n_entry.rising      = rise1;
            n_entry.bright_tier = tier1;
            if (rise1) begin
                peak = tier1 ? lste_pkg::LEVEL_MAX : r_normal_peak;
                inc8 = (lvl1 == lste_pkg::LEVEL_MAX) ? lste_pkg::LEVEL_MAX
                                                    : lvl1 + 8'd1;
                // A zero peak parks the star dark.
                if (inc8 >= peak) begin
                    n_entry.level  = peak;
                    n_entry.rising = 1'b0;
                end else begin
                    n_entry.level  = inc8;
                end
            end else if (lvl1 != 8'd0) begin
                n_entry.level = lvl1 - 8'd1;
                if (lvl1 == 8'd1) begin
                    n_entry.bright_tier = 1'b0;
                end
            end else begin
                n_entry.level = 8'd0;
            end
        end

        was_bright = (cur.level != 8'd0) && cur.bright_tier;
        now_bright = (n_entry.level != 8'd0) && n_entry.bright_tier;

        n_live_cnt = r_live_cnt;
        if (r_s1_in_range) begin
            if (now_bright && !was_bright && (r_live_cnt != 8'hFF)) begin
                n_live_cnt = r_live_cnt + 8'd1;
            end else if (was_bright && !now_bright && (r_live_cnt != 8'd0)) begin
                n_live_cnt = r_live_cnt - 8'd1;
            end
        end else begin
            // Out-of-range LED: only the snapshot takes effect.
            n_frame_cnt = r_s1.frame_start ? r_live_cnt : r_frame_cnt;
        end

        n_wb_valid   = r_s1_valid & r_s1_in_range;
        n_brightness = r_s1_in_range ? n_entry.level : 8'd0;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= lste_pkg::MODE_SPARKLE;
            r_sparkle_thrsh <= lste_pkg::RST_SPARKLE_THRSH;
            r_galaxy_thrsh  <= lste_pkg::RST_GALAXY_THRSH;
            r_bright_cap    <= lste_pkg::RST_BRIGHT_CAP;
            r_normal_peak   <= lste_pkg::RST_NORMAL_PEAK;
            r_s1_valid      <= 1'b0;
            r_valid         <= '0;
            r_wb_valid      <= 1'b0;
            r_live_cnt      <= 8'd0;
            r_frame_cnt     <= 8'd0;
            r_wr_ptr        <= 1'b0;
            r_rd_ptr        <= 1'b0;
            r_cnt           <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lste_pkg::CFG_MODE:          r_mode          <= i_cfg_data[0];
                    lste_pkg::CFG_SPARKLE_THRSH: r_sparkle_thrsh <= i_cfg_data[7:0];
                    lste_pkg::CFG_GALAXY_THRSH:  r_galaxy_thrsh  <= i_cfg_data;
                    lste_pkg::CFG_BRIGHT_CAP:    r_bright_cap    <= i_cfg_data[7:0];
                    lste_pkg::CFG_NORMAL_PEAK:   r_normal_peak   <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end

            r_s1_valid <= in_accept;
            r_wb_valid <= n_wb_valid;

            if (r_s1_valid) begin
                r_live_cnt  <= n_live_cnt;
                r_frame_cnt <= n_frame_cnt;
            end
            if (n_wb_valid) begin
                r_valid[s1_addr] <= 1'b1;
            end

            if (r_s1_valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= 2'(occ_next);
        end

        // Payload registers
        if (in_accept) begin
            r_s1          <= i_in;
            r_s1_in_range <= in_range;
        end
        if (n_wb_valid) begin
            r_wb_addr <= s1_addr;
            r_wb_data <= n_entry;
        end
        if (r_s1_valid) begin
            r_buf[r_wr_ptr] <= '{out_index: r_s1.led_index, brightness: n_brightness};
        end
    end

endmodule : led_star_twinkle_engine_core
`default_nettype wire
